[hdl/plcw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plcw_pkg
// Shared types and constants of the capability list walker.
// ----------------------------------------------------------------------------
package plcw_pkg;

    typedef enum logic [1:0] {
        CMD_FIND_STD  = 2'd0,
        CMD_FIND_NEXT = 2'd1,
        CMD_FIND_EXT  = 2'd2,
        CMD_DATA      = 2'd3
    } cmd_kind_t;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_STATUS    = 3'd1,
        PH_PTR       = 3'd2,
        PH_ID        = 3'd3,
        PH_EXT_FIRST = 3'd4,
        PH_EXT_HDR   = 3'd5
    } phase_t;

    localparam logic [1:0] SZ_BYTE  = 2'd0;
    localparam logic [1:0] SZ_WORD  = 2'd1;
    localparam logic [1:0] SZ_DWORD = 2'd2;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic REG_STD_TTL = 1'b0;
    localparam logic REG_EXT_TTL = 1'b1;

    localparam logic [6:0]  STD_TTL_RESET = 7'd48;
    localparam logic [8:0]  EXT_TTL_RESET = 9'd480;
    localparam logic [11:0] STATUS_ADDR   = 12'h006;
    localparam logic [11:0] CAP_PTR_ADDR  = 12'h034;
    localparam logic [11:0] EXT_BASE      = 12'h100;
    localparam logic [7:0]  STD_MIN_PTR   = 8'h40;
    localparam logic [7:0]  ID_END        = 8'hff;
    localparam logic [11:0] POS_MASK      = 12'hffc;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] device;
        logic [15:0] cap_id;
        logic [11:0] start_pos;
        logic [11:0] ext_start;
        logic [31:0] read_data;
        logic        hdr_invalid;
    } cmd_t;

endpackage
`default_nettype wire

[hdl/pci_capability_list_walker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pci_capability_list_walker
// Walks the standard and extended capability lists of a PCI function.
//
// Input channel (s_): start commands (op 0..2) and returned read data (op 3).
// Output channel (m_): tuser 0 is a configuration read request for the host
// to perform and return as a later data transfer; tuser 1 ends the search.
// Every input transfer yields at most one output transfer; data with no
// search running yields none, and a new start drops a running search.
// A result passes from its input transfer through the decode register, then
// the queue, then the walk engine's output register. The walk engine takes
// one transfer per cycle while its output is not stalled; a two-entry queue
// between decode and walk engine absorbs output stalls, and the input stops
// accepting once it and the decode register are full.
// Reset clears the queue and output, idles the walk and loads hop budgets
// 48 and 480. Budgets are written over cfg_we/cfg_index/cfg_wdata.
// ----------------------------------------------------------------------------
module pci_capability_list_walker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [8:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,  // device, cap_id, start_pos, read_data, pad
    input  wire logic [1:0]  s_tuser,  // op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,  // read_device, read_addr, read_size, found,
                                       // found_pos, ttl_left, pad
    output logic             m_tuser   // kind
);

    logic           f_valid;
    logic           f_ready;
    plcw_pkg::cmd_t f_cmd;
    logic           q_valid;
    logic           q_ready;
    plcw_pkg::cmd_t q_cmd;

    plcw_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (f_valid),
        .cmd       (f_cmd),
        .cmd_ready (f_ready)
    );

    plcw_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_cmd)
    );

    plcw_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire

[hdl/plcw_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plcw_front
// Input stage: takes item transfers, decodes the operation and precomputes
// the extended start offset and the header-invalid flag.
// ----------------------------------------------------------------------------
module plcw_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [95:0]   s_tdata,   // device, cap_id, start_pos, read_data, pad
    input  wire logic [1:0]    s_tuser,   // op
    output logic               cmd_valid,
    output plcw_pkg::cmd_t     cmd,
    input  wire logic          cmd_ready
);

    logic           valid_reg;
    plcw_pkg::cmd_t cmd_reg;
    plcw_pkg::cmd_t cmd_next;

    assign s_tready  = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_comb begin
        cmd_next.kind        = plcw_pkg::cmd_kind_t'(s_tuser);
        cmd_next.device      = s_tdata[31:0];
        cmd_next.cap_id      = s_tdata[47:32];
        cmd_next.start_pos   = s_tdata[59:48];
        cmd_next.read_data   = s_tdata[91:60];
        cmd_next.ext_start   = (s_tdata[59:48] < plcw_pkg::EXT_BASE) ?
                               plcw_pkg::EXT_BASE : s_tdata[59:48];
        cmd_next.hdr_invalid = (s_tdata[91:60] == 32'h0000_0000) ||
                               (s_tdata[91:60] == 32'hffff_ffff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule
`default_nettype wire

[hdl/plcw_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plcw_fifo
// Two-entry command queue between the decode stage and the walk engine.
// ----------------------------------------------------------------------------
module plcw_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire plcw_pkg::cmd_t push_data,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output plcw_pkg::cmd_t     pop_data
);

    plcw_pkg::cmd_t mem [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

[hdl/plcw_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plcw_back
// Walk engine: holds the search state and hop budgets, turns each command
// into a read request or a done result, and registers it on the output.
// ----------------------------------------------------------------------------
module plcw_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_we,
    input  wire logic          cfg_index,
    input  wire logic [8:0]    cfg_wdata,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire plcw_pkg::cmd_t cmd,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [71:0]        m_tdata,
    output logic               m_tuser
);

    logic [6:0]       std_ttl_reg;
    logic [8:0]       ext_ttl_reg;
    plcw_pkg::phase_t phase_reg, phase_next;
    logic [11:0]      cur_pos_reg, cur_pos_next;
    logic [8:0]       hops_reg, hops_next;
    logic [31:0]      device_reg, device_next;
    logic [15:0]      cap_reg, cap_next;
    logic [11:0]      origin_reg, origin_next;

    logic             m_valid_reg;
    logic             kind_reg;
    logic [67:0]      payload_reg;

    logic             fire;
    logic             emit_rd;
    logic             emit_done;
    logic [11:0]      rd_addr;
    logic [1:0]       rd_size;
    logic             hit;
    logic [11:0]      hit_pos;
    logic             std_hop;
    logic [11:0]      hop_pos;
    logic [8:0]       hop_budget;
    logic             ext_visit;
    logic [11:0]      ext_next;
    logic [8:0]       ext_left;
    logic [67:0]      payload_next;

    assign fire      = cmd_valid && (!m_valid_reg || m_tready);
    assign cmd_ready = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tuser   = kind_reg;
    assign m_tdata   = {4'd0, payload_reg};

    always_comb begin
        phase_next   = phase_reg;
        cur_pos_next = cur_pos_reg;
        hops_next    = hops_reg;
        device_next  = device_reg;
        cap_next     = cap_reg;
        origin_next  = origin_reg;
        emit_rd      = 1'b0;
        emit_done    = 1'b0;
        rd_addr      = 12'd0;
        rd_size      = plcw_pkg::SZ_BYTE;
        hit          = 1'b0;
        hit_pos      = 12'd0;
        std_hop      = 1'b0;
        hop_pos      = 12'd0;
        hop_budget   = 9'd0;
        ext_visit    = 1'b0;
        ext_next     = {cmd.read_data[31:22], 2'b00};
        ext_left     = 9'd0;

        if (fire) begin
            unique case (cmd.kind)
                plcw_pkg::CMD_FIND_STD: begin
                    device_next  = cmd.device;
                    cap_next     = cmd.cap_id;
                    origin_next  = cmd.start_pos;
                    hops_next    = {2'b00, std_ttl_reg};
                    cur_pos_next = plcw_pkg::CAP_PTR_ADDR;
                    phase_next   = plcw_pkg::PH_STATUS;
                    emit_rd      = 1'b1;
                    rd_addr      = plcw_pkg::STATUS_ADDR;
                    rd_size      = plcw_pkg::SZ_WORD;
                end
                plcw_pkg::CMD_FIND_NEXT: begin
                    device_next = cmd.device;
                    cap_next    = cmd.cap_id;
                    origin_next = cmd.start_pos;
                    std_hop     = 1'b1;
                    hop_pos     = cmd.start_pos;
                    hop_budget  = {2'b00, std_ttl_reg};
                end
                plcw_pkg::CMD_FIND_EXT: begin
                    device_next  = cmd.device;
                    cap_next     = cmd.cap_id;
                    origin_next  = cmd.start_pos;
                    hops_next    = ext_ttl_reg;
                    cur_pos_next = cmd.ext_start;
                    phase_next   = plcw_pkg::PH_EXT_FIRST;
                    emit_rd      = 1'b1;
                    rd_addr      = cmd.ext_start;
                    rd_size      = plcw_pkg::SZ_DWORD;
                end
                plcw_pkg::CMD_DATA: begin
                    unique case (phase_reg)
                        plcw_pkg::PH_STATUS: begin
                            if (!cmd.read_data[4]) begin
                                emit_done = 1'b1;
                            end else begin
                                std_hop    = 1'b1;
                                hop_pos    = plcw_pkg::CAP_PTR_ADDR;
                                hop_budget = hops_reg;
                            end
                        end
                        plcw_pkg::PH_PTR: begin
                            if (cmd.read_data[7:0] < plcw_pkg::STD_MIN_PTR) begin
                                emit_done = 1'b1;
                            end else begin
                                cur_pos_next = {4'd0, cmd.read_data[7:2], 2'b00};
                                phase_next   = plcw_pkg::PH_ID;
                                emit_rd      = 1'b1;
                                rd_addr      = {4'd0, cmd.read_data[7:2], 2'b00};
                                rd_size      = plcw_pkg::SZ_BYTE;
                            end
                        end
                        plcw_pkg::PH_ID: begin
                            if (cmd.read_data[7:0] == plcw_pkg::ID_END) begin
                                emit_done = 1'b1;
                            end else if ({8'd0, cmd.read_data[7:0]} == cap_reg) begin
                                emit_done = 1'b1;
                                hit       = 1'b1;
                                hit_pos   = cur_pos_reg;
                            end else begin
                                std_hop    = 1'b1;
                                hop_pos    = cur_pos_reg + 12'd1;
                                hop_budget = hops_reg;
                            end
                        end
                        plcw_pkg::PH_EXT_FIRST: begin
                            if (cmd.hdr_invalid) begin
                                emit_done = 1'b1;
                            end else begin
                                ext_visit = 1'b1;
                            end
                        end
                        plcw_pkg::PH_EXT_HDR: begin
                            ext_visit = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end

        if (std_hop) begin
            cur_pos_next = hop_pos;
            if (hop_budget == 9'd0) begin
                hops_next = 9'd0;
                emit_done = 1'b1;
            end else begin
                hops_next  = hop_budget - 9'd1;
                phase_next = plcw_pkg::PH_PTR;
                emit_rd    = 1'b1;
                rd_addr    = hop_pos;
                rd_size    = plcw_pkg::SZ_BYTE;
            end
        end

        if (ext_visit) begin
            if (hops_reg == 9'd0) begin
                emit_done = 1'b1;
            end else begin
                ext_left  = hops_reg - 9'd1;
                hops_next = ext_left;
                if ((cmd.read_data[15:0] == cap_reg) && (cur_pos_reg != origin_reg)) begin
                    emit_done = 1'b1;
                    hit       = 1'b1;
                    hit_pos   = cur_pos_reg;
                end else if (ext_next < plcw_pkg::EXT_BASE) begin
                    emit_done = 1'b1;
                end else begin
                    cur_pos_next = ext_next;
                    phase_next   = plcw_pkg::PH_EXT_HDR;
                    emit_rd      = 1'b1;
                    rd_addr      = ext_next;
                    rd_size      = plcw_pkg::SZ_DWORD;
                end
            end
        end

        if (emit_done) begin
            phase_next = plcw_pkg::PH_IDLE;
        end

        if (emit_done) begin
            payload_next = {hops_next, hit_pos & plcw_pkg::POS_MASK, hit,
                            2'b00, 12'd0, 32'd0};
        end else begin
            payload_next = {9'd0, 12'd0, 1'b0, rd_size, rd_addr, device_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= plcw_pkg::PH_IDLE;
            std_ttl_reg <= plcw_pkg::STD_TTL_RESET;
            ext_ttl_reg <= plcw_pkg::EXT_TTL_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    plcw_pkg::REG_STD_TTL: std_ttl_reg <= cfg_wdata[6:0];
                    plcw_pkg::REG_EXT_TTL: ext_ttl_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (fire) begin
                m_valid_reg <= emit_rd || emit_done;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_pos_reg <= cur_pos_next;
        hops_reg    <= hops_next;
        device_reg  <= device_next;
        cap_reg     <= cap_next;
        origin_reg  <= origin_next;
        if (fire) begin
            kind_reg    <= emit_done ? plcw_pkg::KIND_DONE : plcw_pkg::KIND_READ;
            payload_reg <= payload_next;
        end
    end

    // data arriving with no search running produces nothing
    a_idle_data_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && cmd.kind == plcw_pkg::CMD_DATA && phase_reg == plcw_pkg::PH_IDLE)
        |=> !m_tvalid)
        else $error("result produced for data while idle");

    a_done_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && emit_done) |=> (phase_reg == plcw_pkg::PH_IDLE))
        else $error("walk still running after done result");

    a_miss_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == plcw_pkg::KIND_DONE && !m_tdata[46])
        |-> (m_tdata[58:47] == 12'd0))
        else $error("nonzero position on a miss");

    a_never_both: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |-> !(emit_rd && emit_done))
        else $error("read request and done in one step");

endmodule
`default_nettype wire
